### rtl/core/lsm_pkg.sv
// ============================================================================
// lsm_pkg
// Shared types, codes and helpers of the line substring matcher.
// ============================================================================
package lsm_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int LEN_BITS       = 5;

    // Widths of the result fields on the port.
    localparam int LINE_BITS         = 32;
    localparam int FIELD_OFFSET_BITS = 16;
    localparam int FIELD_COUNT_BITS  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_IGNORE_CASE    = 3'd3,
        CFG_INVERT_MATCH   = 3'd4,
        CFG_REPORT_MODE    = 3'd5
    } t_cfg_index;

    // Report mode bits: bit 1 (list) wins over bit 0 (count).
    localparam int MODE_COUNT_BIT = 0;
    localparam int MODE_LIST_BIT  = 1;

    typedef enum logic {
        KIND_LINE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_result_kind;

    typedef struct packed {
        t_result_kind                 kind;
        logic [LINE_BITS-1:0]         line_number;
        logic [FIELD_OFFSET_BITS-1:0] match_start;
        logic [FIELD_OFFSET_BITS-1:0] match_end;
        logic [FIELD_COUNT_BITS-1:0]  match_count;
        logic                         any_found;
        logic                         last_result;
    } t_result;

    // Control handed to every cell of the window chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_BITS = $clog2(RESULT_DEPTH);
    localparam int RESULT_CNT_BITS = $clog2(RESULT_DEPTH + 1);

    // ASCII lower-case folding, applied only when ignore_case is set.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
        logic [7:0] r;
        r = c;
        if (ic && c >= 8'd65 && c <= 8'd90) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

### rtl/core/lsm_if.sv
// ============================================================================
// lsm_in_if / lsm_out_if
// Valid/ready channels of the line substring matcher.
// ============================================================================
interface lsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_stream;

    modport source (output valid, output text_byte, output end_of_stream, input ready);
    modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

interface lsm_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] line_number;
    logic [15:0] match_start;
    logic [15:0] match_end;
    logic [31:0] match_count;
    logic        any_found;
    logic        last_result;

    modport source (output valid, output result_kind, output line_number,
                    output match_start, output match_end, output match_count,
                    output any_found, output last_result, input ready);
    modport sink   (input valid, input result_kind, input line_number,
                    input match_start, input match_end, input match_count,
                    input any_found, input last_result, output ready);
endinterface

### rtl/core/lsm_cell.sv
// ============================================================================
// lsm_cell
// One window cell: holds a text byte, passes it on, compares it to the
// pattern byte that lines up with this place.
// ============================================================================
module lsm_cell #(
    parameter int IDX           = 0,
    parameter int PATTERN_BYTES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lsm_pkg::t_cell_ctl        i_ctl,
    input  logic [7:0]                i_byte,
    input  logic [7:0]                i_pattern [PATTERN_BYTES],
    input  logic [lsm_pkg::LEN_BITS-1:0] i_len,
    input  logic                      i_ignore_case,
    output logic [7:0]                o_byte,
    output logic                      o_eq
);
    import lsm_pkg::*;

    localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    logic [7:0]          r_byte;
    logic                active;
    logic [LEN_BITS-1:0] pat_idx;
    logic [7:0]          pat_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_byte <= 8'd0;
        end else if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    // The byte entering this cell is compared, so the hit is known in the
    // cycle the byte arrives.
    assign active   = LEN_BITS'(IDX) < i_len;
    assign pat_idx  = i_len - LEN_BITS'(IDX + 1);
    assign pat_byte = active ? i_pattern[pat_idx[IW-1:0]] : 8'd0;
    assign o_eq     = !active ||
                      (fold_byte(pat_byte, i_ignore_case) == fold_byte(i_byte, i_ignore_case));
    assign o_byte   = r_byte;

endmodule

### rtl/core/lsm_result_fifo.sv
// ============================================================================
// lsm_result_fifo
// Small result queue: takes up to two results a cycle, drives the output.
// ============================================================================
module lsm_result_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_count,
    input  lsm_pkg::t_result    i_res [2],
    output logic                o_room,
    lsm_out_if.source           o_out
);
    import lsm_pkg::*;

    t_result                    r_mem [RESULT_DEPTH];
    logic [RESULT_PTR_BITS-1:0] r_wr;
    logic [RESULT_PTR_BITS-1:0] r_rd;
    logic [RESULT_CNT_BITS-1:0] r_count;
    logic                       pop;
    logic [RESULT_PTR_BITS-1:0] wr_next;

    assign pop     = o_out.valid && o_out.ready;
    assign wr_next = r_wr + RESULT_PTR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_res[0];
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + RESULT_PTR_BITS'(i_push_count);
            r_rd    <= r_rd + RESULT_PTR_BITS'(pop);
            r_count <= r_count + RESULT_CNT_BITS'(i_push_count) - RESULT_CNT_BITS'(pop);
        end
    end

    // Room for the worst case of one transaction: two results.
    assign o_room = r_count <= RESULT_CNT_BITS'(RESULT_DEPTH - 2);

    assign o_out.valid       = r_count != '0;
    assign o_out.result_kind = r_mem[r_rd].kind;
    assign o_out.line_number = r_mem[r_rd].line_number;
    assign o_out.match_start = r_mem[r_rd].match_start;
    assign o_out.match_end   = r_mem[r_rd].match_end;
    assign o_out.match_count = r_mem[r_rd].match_count;
    assign o_out.any_found   = r_mem[r_rd].any_found;
    assign o_out.last_result = r_mem[r_rd].last_result;

endmodule

### rtl/core/line_substring_matcher.sv
// ============================================================================
// line_substring_matcher
// Fixed-string line search over a byte stream, one byte per clock while the result queue has room.
// ============================================================================
// The block takes one input transaction per clock: a text byte, or an end of
// stream marker. Every byte shifts into a chain of PATTERN_BYTES window cells,
// and all cells compare against the pattern in the same cycle, so a match is
// known the cycle the last pattern byte arrives and the line state updates in
// that same cycle. A newline closes the line and may queue one line report; an
// end of stream marker queues the summary, after any line report. Results go
// into a four-entry queue that drives the output channel; a result can be
// taken the cycle after the transaction that caused it. i_in.ready is low only
// while the queue has fewer than two free entries, so with the output side
// always ready the block sustains one byte every cycle, and it keeps taking
// bytes that cause no result while a result waits. Configuration writes take
// effect from the next byte and are meant to happen between transactions.
module line_substring_matcher #(
    parameter int PATTERN_BYTES = 16,
    parameter int OFFSET_BITS   = 16,
    parameter int COUNT_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lsm_in_if.sink                            i_in,
    lsm_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [lsm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lsm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import lsm_pkg::*;

    localparam logic [LEN_BITS-1:0]    LEN_MAX   = LEN_BITS'(PATTERN_BYTES);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX   = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX  = '1;
    // Largest count that still fits the 32-bit count field.
    localparam logic [COUNT_BITS-1:0]  COUNT_FIELD_MAX = COUNT_BITS'(32'hFFFF_FFFF);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]          r_pattern [PATTERN_BYTES];
    logic [LEN_BITS-1:0] r_pat_len;
    logic                r_ignore_case;
    logic                r_invert;
    logic [1:0]          r_mode;

    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_pat
        if (k < 8) begin : g_low
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pattern[k] <= 8'd0;
                end else if (i_cfg_we && i_cfg_index == CFG_PATTERN_LOW) begin
                    r_pattern[k] <= i_cfg_data[8*k +: 8];
                end
            end
        end else begin : g_high
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pattern[k] <= 8'd0;
                end else if (i_cfg_we && i_cfg_index == CFG_PATTERN_HIGH) begin
                    r_pattern[k] <= i_cfg_data[8*(k-8) +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len     <= '0;
            r_ignore_case <= 1'b0;
            r_invert      <= 1'b0;
            r_mode        <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW, CFG_PATTERN_HIGH: begin
                    // pattern bytes are written per byte above
                end
                CFG_PATTERN_LENGTH: r_pat_len     <= i_cfg_data[LEN_BITS-1:0];
                CFG_IGNORE_CASE:    r_ignore_case <= i_cfg_data[0];
                CFG_INVERT_MATCH:   r_invert      <= i_cfg_data[0];
                CFG_REPORT_MODE:    r_mode        <= i_cfg_data[1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Lengths beyond the window act as a full window.
    logic [LEN_BITS-1:0] len;
    assign len = (r_pat_len > LEN_MAX) ? LEN_MAX : r_pat_len;

    // ------------------------------------------------------------------
    // Stream state
    // ------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] r_line_pos,     n_line_pos;
    logic [LINE_BITS-1:0]   r_cur_line,     n_cur_line;
    logic                   r_line_matched, n_line_matched;
    logic [OFFSET_BITS-1:0] r_first_end,    n_first_end;
    logic                   r_past_zero,    n_past_zero;
    logic [COUNT_BITS-1:0]  r_selected,     n_selected;
    logic                   r_stopped,      n_stopped;

    logic       in_fire;
    logic       fifo_room;
    logic [1:0] push_count;
    t_result    res [2];
    t_cell_ctl  cell_ctl;

    assign i_in.ready = fifo_room;
    assign in_fire    = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Window chain: cell 0 takes the incoming byte, each cell hands its
    // byte to the next one on a shift.
    // ------------------------------------------------------------------
    logic [7:0]               cell_byte [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] cell_eq;
    logic                     window_eq;

    for (genvar c = 0; c < PATTERN_BYTES; c++) begin : g_cell
        logic [7:0] feed;
        if (c == 0) begin : g_head
            assign feed = i_in.text_byte;
        end else begin : g_link
            assign feed = cell_byte[c-1];
        end
        lsm_cell #(
            .IDX           (c),
            .PATTERN_BYTES (PATTERN_BYTES)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_byte        (feed),
            .i_pattern     (r_pattern),
            .i_len         (len),
            .i_ignore_case (r_ignore_case),
            .o_byte        (cell_byte[c]),
            .o_eq          (cell_eq[c])
        );
    end

    assign window_eq = &cell_eq;

    // ------------------------------------------------------------------
    // Per-transaction update
    // ------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] seen;
    logic                   zero_now;
    logic                   shift_en;
    logic                   hit_raw;
    logic                   hit;
    logic [OFFSET_BITS-1:0] cl_me;
    logic [OFFSET_BITS-1:0] cl_ms;
    logic [LINE_BITS-1:0]   cl_line;
    logic [COUNT_BITS-1:0]  cl_sel;
    logic                   cl_report;
    logic                   cl_stop;
    logic                   do_close;
    logic [COUNT_BITS-1:0]  sum_sel;
    t_result                line_res;
    t_result                sum_res;

    always_comb begin
        // Byte step: saturating position, zero byte ends the searchable part.
        seen     = (r_line_pos < OFF_MAX) ? r_line_pos + OFFSET_BITS'(1) : r_line_pos;
        zero_now = r_past_zero || (i_in.text_byte == 8'd0);
        shift_en = !zero_now && !r_line_matched && (len != '0);

        // Line close: leftmost match offsets, invert, saturating counters.
        hit_raw = (len == '0) || r_line_matched;
        cl_me   = (hit_raw && len != '0) ? r_first_end : '0;
        cl_ms   = cl_me - OFFSET_BITS'(len);
        hit     = hit_raw;
        if (r_invert) begin
            hit   = !hit_raw;
            cl_me = '0;
            cl_ms = '0;
        end
        cl_line   = (r_cur_line != LINE_MAX) ? r_cur_line + LINE_BITS'(1) : r_cur_line;
        cl_sel    = (hit && r_selected != COUNT_MAX) ? r_selected + COUNT_BITS'(1)
                                                     : r_selected;
        cl_report = hit && !r_mode[MODE_LIST_BIT] && !r_mode[MODE_COUNT_BIT];
        cl_stop   = hit && r_mode[MODE_LIST_BIT];

        line_res.kind        = KIND_LINE;
        line_res.line_number = cl_line;
        line_res.match_start = FIELD_OFFSET_BITS'(cl_ms);
        line_res.match_end   = FIELD_OFFSET_BITS'(cl_me);
        line_res.match_count = (cl_sel > COUNT_FIELD_MAX) ? '1 : FIELD_COUNT_BITS'(cl_sel);
        line_res.any_found   = cl_sel != '0;
        line_res.last_result = 1'b1;

        // End of stream closes a partial line first unless stopped.
        do_close = !r_stopped && (r_line_pos != '0);
        sum_sel  = do_close ? cl_sel : r_selected;
        sum_res.kind        = KIND_SUMMARY;
        sum_res.line_number = do_close ? cl_line : r_cur_line;
        sum_res.match_start = '0;
        sum_res.match_end   = '0;
        sum_res.match_count = (sum_sel > COUNT_FIELD_MAX) ? '1 : FIELD_COUNT_BITS'(sum_sel);
        sum_res.any_found   = sum_sel != '0;
        sum_res.last_result = 1'b1;

        // Hold by default.
        n_line_pos     = r_line_pos;
        n_cur_line     = r_cur_line;
        n_line_matched = r_line_matched;
        n_first_end    = r_first_end;
        n_past_zero    = r_past_zero;
        n_selected     = r_selected;
        n_stopped      = r_stopped;
        push_count     = 2'd0;
        res[0]         = line_res;
        res[1]         = sum_res;
        cell_ctl       = '0;

        if (in_fire) begin
            if (i_in.end_of_stream) begin
                if (do_close && cl_report) begin
                    res[0].last_result = 1'b0;
                    push_count         = 2'd2;
                end else begin
                    res[0]     = sum_res;
                    push_count = 2'd1;
                end
                // Return all stream state to reset; configuration registers stay.
                n_line_pos     = '0;
                n_cur_line     = '0;
                n_line_matched = 1'b0;
                n_first_end    = '0;
                n_past_zero    = 1'b0;
                n_selected     = '0;
                n_stopped      = 1'b0;
                cell_ctl.clear = 1'b1;
            end else if (!r_stopped) begin
                if (i_in.text_byte == NEWLINE_BYTE) begin
                    n_cur_line     = cl_line;
                    n_selected     = cl_sel;
                    n_stopped      = cl_stop;
                    n_line_pos     = '0;
                    n_line_matched = 1'b0;
                    n_first_end    = '0;
                    n_past_zero    = 1'b0;
                    if (cl_report) begin
                        push_count = 2'd1;
                    end
                end else begin
                    n_past_zero    = zero_now;
                    n_line_pos     = seen;
                    cell_ctl.shift = shift_en;
                    // Record only the leftmost match of the line.
                    if (shift_en && window_eq && seen >= OFFSET_BITS'(len)) begin
                        n_line_matched = 1'b1;
                        n_first_end    = seen;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos     <= '0;
            r_cur_line     <= '0;
            r_line_matched <= 1'b0;
            r_first_end    <= '0;
            r_past_zero    <= 1'b0;
            r_selected     <= '0;
            r_stopped      <= 1'b0;
        end else begin
            r_line_pos     <= n_line_pos;
            r_cur_line     <= n_cur_line;
            r_line_matched <= n_line_matched;
            r_first_end    <= n_first_end;
            r_past_zero    <= n_past_zero;
            r_selected     <= n_selected;
            r_stopped      <= n_stopped;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and output channel
    // ------------------------------------------------------------------
    lsm_result_fifo u_result_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res        (res),
        .o_room       (fifo_room),
        .o_out        (o_out)
    );

endmodule

### rtl/core/lsm_checker.sv
// ============================================================================
// lsm_checker
// Port-level checks of the line substring matcher, bound to the top level.
// ============================================================================
module lsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_result_kind,
    input logic [31:0] i_line_number,
    input logic [31:0] i_match_count,
    input logic        i_any_found,
    input logic        i_last_result
);
    import lsm_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // The summary is always the last result of its transaction.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind == KIND_SUMMARY |-> i_last_result)
        else $error("summary without last_result");

    // The found flag follows the selected-line count.
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_any_found == (i_match_count != 32'd0)))
        else $error("any_found disagrees with match_count");

    // A line report names a real line and counts itself.
    a_line_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind == KIND_LINE |->
            (i_line_number != 32'd0) && (i_match_count != 32'd0))
        else $error("line report with zero line number or count");

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_result_kind (o_out.result_kind),
    .i_line_number (o_out.line_number),
    .i_match_count (o_out.match_count),
    .i_any_found   (o_out.any_found),
    .i_last_result (o_out.last_result)
);
